### rtl/core/multiplexed_servo_pulse_scheduler_macros.svh
// Assertion macros shared by the servo pulse scheduler checkers.
// No dependencies; expects a clock and a reset in the enclosing scope.
`ifndef MULTIPLEXED_SERVO_PULSE_SCHEDULER_MACROS_SVH
`define MULTIPLEXED_SERVO_PULSE_SCHEDULER_MACROS_SVH

// same-cycle implication
`define MSPS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MSPS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/msps_pkg.sv
// Package for the servo pulse scheduler: codes, widths, reset values, result type.
// No dependencies.
package msps_pkg;

   localparam int CHANNELS_DEF = 16;
   localparam int WIDTH_W      = 16;
   localparam int SLOT_W       = 7;
   localparam int OVH_W        = 8;
   localparam int TIMER_W      = 8;
   localparam int CSR_AW       = 3;
   localparam int CSR_DW       = 32;

   localparam logic [SLOT_W-1:0]  SLOT_TIME_RST = 7'd100;
   localparam logic [OVH_W-1:0]   SLOT_OVH_RST  = 8'd27;
   localparam logic [WIDTH_W-1:0] WIDTH_RST     = 16'd500;

   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_EXP0  = 2'd1;
   localparam logic [1:0] CMD_EXP1  = 2'd2;
   localparam logic [1:0] CMD_WRITE = 2'd3;

   localparam logic [1:0] ACT_NONE = 2'd0;
   localparam logic [1:0] ACT_HIGH = 2'd1;
   localparam logic [1:0] ACT_LOW  = 2'd2;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_DISABLED = 2'd1;
   localparam logic [1:0] STAT_ALL_BUSY = 2'd2;
   localparam logic [1:0] STAT_IDLE_EXP = 2'd3;

   localparam logic REG_SLOT_TIME = 1'b0;
   localparam logic REG_SLOT_OVH  = 1'b1;

   typedef struct packed {
      logic [1:0]         status;
      logic [TIMER_W-1:0] timer_load;
      logic               timer_load_valid;
      logic               engine;
      logic [3:0]         pin_channel;
      logic [1:0]         pin_action;
   } res_type;

endpackage

### rtl/core/msps_chan_mem.sv
// Channel table: width and enable per channel, synchronous read, one write port.
// Uses msps_pkg; unwritten entries read as the reset width and enabled.
module msps_chan_mem #(
   parameter int CHANNELS = msps_pkg::CHANNELS_DEF,
   parameter int AW       = $clog2(CHANNELS)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic [msps_pkg::WIDTH_W-1:0] wr_width,
   input  logic                         wr_enable,
   input  logic                         rd_en,
   input  logic [AW-1:0]                rd_addr,
   output logic [msps_pkg::WIDTH_W-1:0] rd_width,
   output logic                         rd_enable
);
   import msps_pkg::*;

   logic [WIDTH_W:0]    mem [CHANNELS];
   logic [CHANNELS-1:0] vld_ff;
   logic [WIDTH_W:0]    rd_data_ff;
   logic                rd_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_enable, wr_width};
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_vld_ff  <= vld_ff[rd_addr];
      end
   end

   assign rd_width  = rd_vld_ff ? rd_data_ff[WIDTH_W-1:0] : WIDTH_RST;
   assign rd_enable = rd_vld_ff ? rd_data_ff[WIDTH_W] : 1'b1;

endmodule

### rtl/core/msps_divider.sv
// Serial restoring divider, one quotient bit per cycle (width / slot time).
// Uses msps_pkg; divisor must be nonzero.
module msps_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [msps_pkg::WIDTH_W-1:0] dividend,
   input  logic [msps_pkg::SLOT_W-1:0]  divisor,
   output logic                         done,
   output logic [msps_pkg::WIDTH_W-1:0] quot,
   output logic [msps_pkg::SLOT_W-1:0]  rem
);
   import msps_pkg::*;

   localparam int CNT_W = $clog2(WIDTH_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [WIDTH_W-1:0] q_ff, q_in;
   logic [SLOT_W-1:0]  rem_ff, rem_in;
   logic [SLOT_W-1:0]  d_ff, d_in;
   logic [SLOT_W:0]    trial;
   logic               ge;

   always_comb begin
      trial   = {rem_ff, q_ff[WIDTH_W-1]};
      ge      = trial >= {1'b0, d_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      d_in    = d_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = dividend;
         rem_in  = '0;
         d_in    = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? SLOT_W'(trial - {1'b0, d_ff}) : trial[SLOT_W-1:0];
         q_in   = {q_ff[WIDTH_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(WIDTH_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      d_ff   <= d_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
   assign rem  = rem_ff;

endmodule

### rtl/core/multiplexed_servo_pulse_scheduler.sv
// Servo pulse scheduler top level: stream ports, CSR port, control and engine state.
// Uses msps_pkg, msps_chan_mem and msps_divider.
//
// One transaction in, one result out. A frame-slot tick on an enabled channel with
// an idle engine runs as follows from one accept to the next: the accept cycle issues
// the channel table read, ST_DEC picks the engine and starts the divider, ST_DIV waits
// for the bit-serial width / slot_time division and collects quotient and remainder,
// and ST_OUT hands the result to the output register. Ticks that skip a channel go
// from ST_DEC to ST_OUT; engine expiries and channel writes go from ST_IDLE to ST_OUT.
// The block works on one transaction at a time; a result waiting in the output register
// does not block the next input, but that input's result waits until it frees up.
module multiplexed_servo_pulse_scheduler #(
   parameter int CHANNELS = msps_pkg::CHANNELS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [23:0]                 req_tdata,  // channel[3:0], width[19:4], enable[20]
   input  logic [1:0]                  req_tuser,  // command[1:0]
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // pin_action[1:0], pin_channel[5:2], engine[6], timer_load_valid[7], timer_load[15:8]
   output logic [15:0]                 rsp_tdata,
   output logic [1:0]                  rsp_tuser,  // status[1:0]
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [msps_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [msps_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [msps_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);
   import msps_pkg::*;

   localparam int CH_AW = $clog2(CHANNELS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DEC  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [OVH_W-1:0]   ovh_ff, ovh_in;
   logic [CH_AW-1:0]   next_ch_ff, next_ch_in;
   logic [CH_AW-1:0]   cur_ch_ff, cur_ch_in;
   logic [1:0]         eng_busy_ff, eng_busy_in;
   logic [CH_AW-1:0]   eng_owner_ff [2];
   logic [CH_AW-1:0]   eng_owner_in [2];
   logic [WIDTH_W-1:0] eng_slots_ff [2];
   logic [WIDTH_W-1:0] eng_slots_in [2];
   logic               eng_sel_ff, eng_sel_in;
   res_type            res_ff, res_in;
   res_type            out_ff, out_in;
   logic               out_vld_ff, out_vld_in;

   logic               accept;
   logic               csr_wr;
   logic [1:0]         cmd;
   logic [3:0]         req_channel;
   logic [WIDTH_W-1:0] req_width;
   logic               req_enable;
   logic [SLOT_W-1:0]  slot_eff;
   logic [SLOT_W+1:0]  reload_sum;
   logic [TIMER_W-1:0] reload_val;
   logic [TIMER_W-1:0] header;
   logic               mem_wr;
   logic               mem_rd;
   logic [WIDTH_W-1:0] ch_width;
   logic               ch_enable;
   logic               div_start;
   logic               div_done;
   logic [WIDTH_W-1:0] div_quot;
   logic [SLOT_W-1:0]  div_rem;
   logic               exp_eng;

   assign cmd         = req_tuser;
   assign req_channel = req_tdata[3:0];
   assign req_width   = req_tdata[19:4];
   assign req_enable  = req_tdata[20];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign slot_eff   = (slot_ff == '0) ? SLOT_W'(1) : slot_ff;
   assign reload_sum = {2'b00, slot_eff} + {1'b0, ovh_ff};
   assign reload_val = reload_sum[SLOT_W+1] ? '0 : ~reload_sum[TIMER_W-1:0];
   assign header     = {1'b0, div_rem} + {1'b0, slot_eff};
   assign exp_eng    = (cmd == CMD_EXP1);

   assign mem_rd = accept && (cmd == CMD_TICK);
   assign mem_wr = accept && (cmd == CMD_WRITE) && (int'(req_channel) < CHANNELS);

   always_comb begin
      case (csr_paddr[2])
         REG_SLOT_TIME: csr_prdata = CSR_DW'(slot_ff);
         REG_SLOT_OVH:  csr_prdata = CSR_DW'(ovh_ff);
         default:       csr_prdata = '0;
      endcase
   end

   msps_chan_mem #(
      .CHANNELS (CHANNELS),
      .AW       (CH_AW)
   ) u_chan_mem (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (mem_wr),
      .wr_addr   (CH_AW'(req_channel)),
      .wr_width  (req_width),
      .wr_enable (req_enable),
      .rd_en     (mem_rd),
      .rd_addr   (next_ch_ff),
      .rd_width  (ch_width),
      .rd_enable (ch_enable)
   );

   msps_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (ch_width),
      .divisor  (slot_eff),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      ovh_in       = ovh_ff;
      next_ch_in   = next_ch_ff;
      cur_ch_in    = cur_ch_ff;
      eng_busy_in  = eng_busy_ff;
      eng_owner_in = eng_owner_ff;
      eng_slots_in = eng_slots_ff;
      eng_sel_in   = eng_sel_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_vld_in   = out_vld_ff;
      div_start    = 1'b0;

      if (csr_wr) begin
         case (csr_paddr[2])
            REG_SLOT_TIME: slot_in = csr_pwdata[SLOT_W-1:0];
            REG_SLOT_OVH:  ovh_in  = csr_pwdata[OVH_W-1:0];
            default:       ;
         endcase
      end

      if (out_vld_ff && rsp_tready) begin
         out_vld_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_in = '0;
               case (cmd)
                  CMD_TICK: begin
                     cur_ch_in  = next_ch_ff;
                     next_ch_in = (next_ch_ff == CH_AW'(CHANNELS - 1)) ?
                                  '0 : next_ch_ff + 1'b1;
                     state_in   = ST_DEC;
                  end
                  CMD_EXP0, CMD_EXP1: begin
                     res_in.engine = exp_eng;
                     if (!eng_busy_ff[exp_eng]) begin
                        res_in.status = STAT_IDLE_EXP;
                     end else if (eng_slots_ff[exp_eng] == '0) begin
                        eng_busy_in[exp_eng] = 1'b0;
                        res_in.pin_action    = ACT_LOW;
                        res_in.pin_channel   = 4'(eng_owner_ff[exp_eng]);
                     end else begin
                        eng_slots_in[exp_eng]   = eng_slots_ff[exp_eng] - 1'b1;
                        res_in.pin_channel      = 4'(eng_owner_ff[exp_eng]);
                        res_in.timer_load_valid = 1'b1;
                        res_in.timer_load       = reload_val;
                     end
                     state_in = ST_OUT;
                  end
                  default: begin
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_DEC: begin
            res_in.pin_channel = 4'(cur_ch_ff);
            if (!ch_enable) begin
               res_in.status = STAT_DISABLED;
               state_in      = ST_OUT;
            end else if (eng_busy_ff[0] && eng_busy_ff[1]) begin
               res_in.status = STAT_ALL_BUSY;
               state_in      = ST_OUT;
            end else begin
               eng_sel_in = eng_busy_ff[0];
               div_start  = 1'b1;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               eng_busy_in[eng_sel_ff]  = 1'b1;
               eng_owner_in[eng_sel_ff] = cur_ch_ff;
               eng_slots_in[eng_sel_ff] = (div_quot == '0) ? '0 : div_quot - 1'b1;
               res_in.pin_action        = ACT_HIGH;
               res_in.engine            = eng_sel_ff;
               res_in.timer_load_valid  = 1'b1;
               res_in.timer_load        = ~header;
               state_in                 = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!out_vld_ff || rsp_tready) begin
               out_in     = res_ff;
               out_vld_in = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= SLOT_TIME_RST;
         ovh_ff       <= SLOT_OVH_RST;
         next_ch_ff   <= '0;
         eng_busy_ff  <= '0;
         eng_owner_ff <= '{default: '0};
         eng_slots_ff <= '{default: '0};
         out_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         ovh_ff       <= ovh_in;
         next_ch_ff   <= next_ch_in;
         eng_busy_ff  <= eng_busy_in;
         eng_owner_ff <= eng_owner_in;
         eng_slots_ff <= eng_slots_in;
         out_vld_ff   <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ch_ff  <= cur_ch_in;
      eng_sel_ff <= eng_sel_in;
      res_ff     <= res_in;
      out_ff     <= out_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {out_ff.timer_load, out_ff.timer_load_valid, out_ff.engine,
                        out_ff.pin_channel, out_ff.pin_action};
   assign rsp_tuser  = out_ff.status;

endmodule

### rtl/core/msps_checker.sv
// Port-level checks for the servo pulse scheduler, bound to the top level.
// Uses msps_pkg and multiplexed_servo_pulse_scheduler_macros.svh.
`include "multiplexed_servo_pulse_scheduler_macros.svh"

module msps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);
   import msps_pkg::*;

   `MSPS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result transaction changed")
   `MSPS_ASSERT_NEXT(a_one_at_a_time, req_tvalid && req_tready, !req_tready, "input taken while a transaction is in work")
   `MSPS_ASSERT_NOW(a_high_loads, rsp_tvalid && rsp_tdata[1:0] == ACT_HIGH, rsp_tdata[7] && rsp_tuser == STAT_OK, "pin driven high without timer load")
   `MSPS_ASSERT_NOW(a_skip_quiet, rsp_tvalid && rsp_tuser != STAT_OK, rsp_tdata[1:0] == ACT_NONE && !rsp_tdata[7], "skipped transaction drives a pin or timer")

endmodule

bind multiplexed_servo_pulse_scheduler msps_checker u_msps_checker (.*);
